@@ hw/rtl/sh64_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sh64_pkg
// Shared constants, types and helper functions of the streaming 64-bit hash.
// ----------------------------------------------------------------------------
package sh64_pkg;

  localparam logic [63:0] K0 = 64'h0000_0000_D6D0_18F5;
  localparam logic [63:0] K1 = 64'h0000_0000_A2AA_033B;
  localparam logic [63:0] K2 = 64'h0000_0000_6299_2FC1;
  localparam logic [63:0] K3 = 64'h0000_0000_30BC_5B29;

  localparam int unsigned QueueDepth = 2;

  // One classified job handed from the front to the back.
  typedef struct packed {
    logic        start;   // load hash from seed first
    logic [63:0] seed;
    logic [63:0] word;
    logic        mix;     // mix a complete stripe ending with word
    logic        emit;    // finish the message and emit a result
    logic [4:0]  tlen;    // tail length in bytes, 0..31
    logic [1:0]  nbuf;    // buffered words that belong to the tail
  } sh64_job_t;

  // Back-end micro-op codes.
  typedef enum logic [4:0] {
    OpIdle, OpStart, OpStartMul,
    OpMA, OpMB, OpMC, OpMD, OpMX1, OpMX2, OpMX3, OpMEnd,
    OpT16A, OpT16B, OpT16C, OpT16D, OpT16E, OpT16F,
    OpT8A, OpT8B, OpT4A, OpT4B, OpT2A, OpT2B, OpT1A, OpT1B,
    OpF1, OpF2, OpOut
  } sh64_op_e;

  function automatic logic [63:0] rotr64(input logic [63:0] v, input int unsigned k);
    rotr64 = (v >> k) | (v << (64 - k));
  endfunction

  function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] k);
    // constants are 32 bits wide: low 64 bits of a 64x32 product, built from
    // a full 32x32 product and the low half of a second one
    logic [63:0] pl;
    logic [31:0] ph;
    pl = a[31:0] * k[31:0];
    ph = a[63:32] * k[31:0];
    mul64 = pl + {ph, 32'd0};
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sh64_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sh64_front
// Accepts message words, counts buffered stripe words and issues one job per word.
// ----------------------------------------------------------------------------
module sh64_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [63:0]         seed_i,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [63:0]         data_word_i,
  input  wire  [3:0]          byte_count_i,
  input  wire                 last_i,
  output logic                job_valid_o,
  input  wire                 job_ready_i,
  output sh64_pkg::sh64_job_t job_o
);
  logic [1:0] words_q, words_d;
  logic       open_q, open_d;
  logic [3:0] cnt;
  logic [1:0] n;

  assign in_ready    = job_ready_i;
  assign job_valid_o = in_valid;
  assign n   = open_q ? words_q : 2'd0;
  assign cnt = (byte_count_i > 4'd8) ? 4'd8 : byte_count_i;

  always_comb begin
    job_o       = '0;
    job_o.start = !open_q;
    job_o.seed  = seed_i;
    job_o.word  = data_word_i;
    job_o.nbuf  = n;
    words_d     = n;
    open_d      = open_q;
    if (!last_i) begin
      open_d = 1'b1;
      if (n == 2'd3) begin
        job_o.mix = 1'b1;
        words_d   = 2'd0;
      end else begin
        words_d = n + 2'd1;
      end
    end else begin
      job_o.emit = 1'b1;
      open_d     = 1'b0;
      words_d    = 2'd0;
      if (n == 2'd3 && cnt == 4'd8) begin
        job_o.mix  = 1'b1;
        job_o.nbuf = 2'd0;
        job_o.tlen = 5'd0;
      end else begin
        job_o.tlen = {n, 3'd0} + {1'b0, cnt};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= 2'd0;
      open_q  <= 1'b0;
    end else if (in_valid && in_ready) begin
      words_q <= words_d;
      open_q  <= open_d;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sh64_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sh64_queue
// Small job FIFO decoupling front and back.
// ----------------------------------------------------------------------------
module sh64_queue #(
  parameter int unsigned Depth = sh64_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 wr_valid_i,
  output logic                wr_ready_o,
  input  sh64_pkg::sh64_job_t wr_data_i,
  output logic                rd_valid_o,
  input  wire                 rd_ready_i,
  output sh64_pkg::sh64_job_t rd_data_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  sh64_pkg::sh64_job_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != Depth[Aw:0];
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr) - (Aw+1)'(rd);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/sh64_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sh64_back
// Sequencer running hash updates, stripe mixing, tail folding and finish.
// ----------------------------------------------------------------------------
module sh64_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 job_valid_i,
  output logic                job_ready_o,
  input  sh64_pkg::sh64_job_t job_i,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [63:0]         hash_value_o
);
  sh64_pkg::sh64_op_e op_q, op_d;
  sh64_pkg::sh64_job_t job_q;
  logic [63:0] h_q, h_d, a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, t_q, t_d;
  logic [63:0] buf_q [3];
  logic [63:0] out_q;
  logic        ov_q;
  logic [4:0]  p_q, p_d;
  logic        take;
  logic [63:0] tw0, tw1, tw, tb;
  logic [1:0]  wi;
  logic [63:0] lo, hi;

  // tail bytes are buffered words then the final word, addressed by p_q
  function automatic logic [63:0] tword(input logic [1:0] i, input logic [1:0] nb,
                                        input logic [63:0] w, input logic [63:0] b0,
                                        input logic [63:0] b1, input logic [63:0] b2);
    logic [63:0] r;
    r = w;
    if (i < nb) begin
      unique case (i)
        2'd0:    r = b0;
        2'd1:    r = b1;
        default: r = b2;
      endcase
    end
    tword = r;
  endfunction

  assign wi  = p_q[4:3];
  assign tw0 = tword(wi, job_q.nbuf, job_q.word, buf_q[0], buf_q[1], buf_q[2]);
  assign tw1 = tword(wi + 2'd1, job_q.nbuf, job_q.word, buf_q[0], buf_q[1], buf_q[2]);
  // tail word at byte p_q, masked to the bytes in the message
  always_comb begin
    logic [127:0] pair;
    logic [5:0]   sh;
    logic [5:0]   rem;
    pair = {tw1, tw0};
    sh   = {p_q[2:0], 3'd0};
    tw   = 64'(pair >> sh);
    rem  = 6'(job_q.tlen) - 6'(p_q);
    tb   = tw;
    if (rem < 6'd8) tb = tw & ~(64'hFFFF_FFFF_FFFF_FFFF << {rem[2:0], 3'd0});
  end
  assign lo = tb;
  assign hi = tword(wi + 2'd1, job_q.nbuf, job_q.word, buf_q[0], buf_q[1], buf_q[2]);

  assign take        = (op_q == sh64_pkg::OpIdle);
  assign job_ready_o = take;
  assign out_valid   = ov_q;
  assign hash_value_o = out_q;

  // next op; tail decisions look at the bytes left after this step
  always_comb begin
    logic [4:0] rem;
    rem  = job_q.tlen - p_d;
    op_d = op_q;
    unique case (op_q)
      sh64_pkg::OpIdle:     if (job_valid_i) op_d = sh64_pkg::OpStart;
      sh64_pkg::OpStart:    op_d = job_q.start ? sh64_pkg::OpStartMul
                                   : (job_q.mix ? sh64_pkg::OpMA
                                   : (job_q.emit ? sh64_pkg::OpT16A : sh64_pkg::OpIdle));
      sh64_pkg::OpStartMul: op_d = job_q.mix ? sh64_pkg::OpMA
                                   : (job_q.emit ? sh64_pkg::OpT16A : sh64_pkg::OpIdle);
      sh64_pkg::OpMA:  op_d = sh64_pkg::OpMB;
      sh64_pkg::OpMB:  op_d = sh64_pkg::OpMC;
      sh64_pkg::OpMC:  op_d = sh64_pkg::OpMD;
      sh64_pkg::OpMD:  op_d = sh64_pkg::OpMX1;
      sh64_pkg::OpMX1: op_d = sh64_pkg::OpMX2;
      sh64_pkg::OpMX2: op_d = sh64_pkg::OpMX3;
      sh64_pkg::OpMX3: op_d = sh64_pkg::OpMEnd;
      sh64_pkg::OpMEnd: op_d = job_q.emit ? sh64_pkg::OpT16A : sh64_pkg::OpIdle;
      sh64_pkg::OpT16A: op_d = (rem >= 5'd16) ? sh64_pkg::OpT16B
                               : (rem >= 5'd8) ? sh64_pkg::OpT8A
                               : (rem >= 5'd4) ? sh64_pkg::OpT4A
                               : (rem >= 5'd2) ? sh64_pkg::OpT2A
                               : (rem != 5'd0) ? sh64_pkg::OpT1A : sh64_pkg::OpF1;
      sh64_pkg::OpT16B: op_d = sh64_pkg::OpT16C;
      sh64_pkg::OpT16C: op_d = sh64_pkg::OpT16D;
      sh64_pkg::OpT16D: op_d = sh64_pkg::OpT16E;
      sh64_pkg::OpT16E: op_d = sh64_pkg::OpT16F;
      sh64_pkg::OpT16F: op_d = (rem >= 5'd8) ? sh64_pkg::OpT8A
                               : (rem >= 5'd4) ? sh64_pkg::OpT4A
                               : (rem >= 5'd2) ? sh64_pkg::OpT2A
                               : (rem != 5'd0) ? sh64_pkg::OpT1A : sh64_pkg::OpF1;
      sh64_pkg::OpT8A: op_d = sh64_pkg::OpT8B;
      sh64_pkg::OpT8B: op_d = (rem >= 5'd4) ? sh64_pkg::OpT4A
                              : (rem >= 5'd2) ? sh64_pkg::OpT2A
                              : (rem != 5'd0) ? sh64_pkg::OpT1A : sh64_pkg::OpF1;
      sh64_pkg::OpT4A: op_d = sh64_pkg::OpT4B;
      sh64_pkg::OpT4B: op_d = (rem >= 5'd2) ? sh64_pkg::OpT2A
                              : (rem != 5'd0) ? sh64_pkg::OpT1A : sh64_pkg::OpF1;
      sh64_pkg::OpT2A: op_d = sh64_pkg::OpT2B;
      sh64_pkg::OpT2B: op_d = (rem != 5'd0) ? sh64_pkg::OpT1A : sh64_pkg::OpF1;
      sh64_pkg::OpT1A: op_d = sh64_pkg::OpT1B;
      sh64_pkg::OpT1B: op_d = sh64_pkg::OpF1;
      sh64_pkg::OpF1:  op_d = sh64_pkg::OpF2;
      sh64_pkg::OpF2:  op_d = sh64_pkg::OpOut;
      sh64_pkg::OpOut: if (!ov_q || out_ready) op_d = sh64_pkg::OpIdle;
      default:         op_d = sh64_pkg::OpIdle;
    endcase
  end

  // datapath: no step chains two multiplies
  always_comb begin
    h_d = h_q; a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; t_d = t_q; p_d = p_q;
    unique case (op_q)
      sh64_pkg::OpStart:    if (job_q.start) t_d = job_q.seed + sh64_pkg::K2;
      sh64_pkg::OpStartMul: h_d = sh64_pkg::mul64(t_q, sh64_pkg::K0);
      sh64_pkg::OpMA: a_d = sh64_pkg::rotr64(sh64_pkg::mul64(buf_q[0], sh64_pkg::K0), 29) + h_q;
      sh64_pkg::OpMB: b_d = sh64_pkg::rotr64(sh64_pkg::mul64(buf_q[1], sh64_pkg::K1), 29) + h_q;
      sh64_pkg::OpMC: c_d = sh64_pkg::rotr64(sh64_pkg::mul64(buf_q[2], sh64_pkg::K2), 29) + h_q;
      sh64_pkg::OpMD: d_d = sh64_pkg::rotr64(sh64_pkg::mul64(job_q.word, sh64_pkg::K3), 29) + h_q;
      sh64_pkg::OpMX1: t_d = sh64_pkg::rotr64(sh64_pkg::mul64(a_q, sh64_pkg::K0) + d_q, 37);
      sh64_pkg::OpMX2: begin
        a_d = a_q ^ sh64_pkg::mul64(t_q, sh64_pkg::K1);
        t_d = sh64_pkg::rotr64(sh64_pkg::mul64(b_q, sh64_pkg::K1) + c_q, 37);
      end
      // only lanes a and b reach the hash; c and d updates are dropped
      sh64_pkg::OpMX3: b_d = b_q ^ sh64_pkg::mul64(t_q, sh64_pkg::K0);
      sh64_pkg::OpMEnd: h_d = h_q + (a_q ^ b_q);
      sh64_pkg::OpT16A: p_d = 5'd0;
      sh64_pkg::OpT16B: t_d = h_q + sh64_pkg::mul64(lo, sh64_pkg::K2);
      sh64_pkg::OpT16C: begin
        a_d = sh64_pkg::mul64(sh64_pkg::rotr64(t_q, 29), sh64_pkg::K3);
        b_d = h_q + sh64_pkg::mul64(hi, sh64_pkg::K2);
      end
      sh64_pkg::OpT16D: b_d = sh64_pkg::mul64(sh64_pkg::rotr64(b_q, 29), sh64_pkg::K3);
      sh64_pkg::OpT16E: a_d = a_q ^ (sh64_pkg::rotr64(sh64_pkg::mul64(a_q, sh64_pkg::K0), 21)
                                     + b_q);
      sh64_pkg::OpT16F: begin
        b_d = b_q ^ (sh64_pkg::rotr64(sh64_pkg::mul64(b_q, sh64_pkg::K3), 21) + a_q);
        h_d = h_q + b_d;
        p_d = p_q + 5'd16;
      end
      sh64_pkg::OpT8A: h_d = h_q + sh64_pkg::mul64(lo, sh64_pkg::K3);
      sh64_pkg::OpT4A: h_d = h_q + sh64_pkg::mul64(lo & 64'h0000_0000_FFFF_FFFF, sh64_pkg::K3);
      sh64_pkg::OpT2A: h_d = h_q + sh64_pkg::mul64(lo & 64'h0000_0000_0000_FFFF, sh64_pkg::K3);
      sh64_pkg::OpT1A: h_d = h_q + sh64_pkg::mul64(lo & 64'h0000_0000_0000_00FF, sh64_pkg::K3);
      sh64_pkg::OpT8B: begin
        h_d = h_q ^ sh64_pkg::mul64(sh64_pkg::rotr64(h_q, 55), sh64_pkg::K1);
        p_d = p_q + 5'd8;
      end
      sh64_pkg::OpT4B: begin
        h_d = h_q ^ sh64_pkg::mul64(sh64_pkg::rotr64(h_q, 26), sh64_pkg::K1);
        p_d = p_q + 5'd4;
      end
      sh64_pkg::OpT2B: begin
        h_d = h_q ^ sh64_pkg::mul64(sh64_pkg::rotr64(h_q, 48), sh64_pkg::K1);
        p_d = p_q + 5'd2;
      end
      sh64_pkg::OpT1B: begin
        h_d = h_q ^ sh64_pkg::mul64(sh64_pkg::rotr64(h_q, 37), sh64_pkg::K1);
        p_d = p_q + 5'd1;
      end
      sh64_pkg::OpF1: t_d = sh64_pkg::mul64(h_q ^ sh64_pkg::rotr64(h_q, 28), sh64_pkg::K0);
      sh64_pkg::OpF2: t_d = t_q ^ sh64_pkg::rotr64(t_q, 29);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; t_q <= t_d;
    if (take && job_valid_i) job_q <= job_i;
    // buffer non-last, non-mixing words into the stripe
    if (op_q == sh64_pkg::OpStart && !job_q.emit && !job_q.mix)
      buf_q[job_q.nbuf] <= job_q.word;
    if (op_q == sh64_pkg::OpOut && (!ov_q || out_ready)) out_q <= t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= sh64_pkg::OpIdle;
      ov_q <= 1'b0;
      p_q  <= 5'd0;
    end else begin
      op_q <= op_d;
      p_q  <= (op_q == sh64_pkg::OpT16A) ? 5'd0 : p_d;
      if (op_q == sh64_pkg::OpOut && (!ov_q || out_ready)) ov_q <= 1'b1;
      else if (ov_q && out_ready) ov_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/stream_hash64.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stream_hash64
// Streaming 64-bit hash of a byte message delivered as little-endian words.
// ----------------------------------------------------------------------------
// A message is a run of 64-bit words closed by one with last set; only that
// word's byte_count matters (0..8, larger counts act as 8). One hash_value
// transfer follows each message. The front classifies each word and pushes
// a job into a two-entry queue; the back runs one sequencer step a cycle
// except while a finished hash waits on out_ready, and no step chains two
// multiplies (each 64x32 product is built from two 32x32 partial products).
// The back takes a new job only when idle; a last word's run depends on tail
// length and whether a stripe is mixed first. The seed register is sampled
// when a message's first word enters the queue.
module stream_hash64 #(
  parameter int unsigned QueueDepth = sh64_pkg::QueueDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [63:0] seed_i,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [63:0] data_word_i,
  input  wire  [3:0]  byte_count_i,
  input  wire         last_i,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] hash_value_o
);
  logic [63:0] seed_q;
  sh64_pkg::sh64_job_t fj, qj;
  logic fv, fr, qv, qr;

  // always take configuration transfers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= 64'd0;
    else if (cfg_valid) seed_q <= seed_i;
  end

  sh64_front u_front (
    .clk_i, .rst_ni, .seed_i(seed_q), .in_valid, .in_ready,
    .data_word_i, .byte_count_i, .last_i,
    .job_valid_o(fv), .job_ready_i(fr), .job_o(fj)
  );

  sh64_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(fj),
    .rd_valid_o(qv), .rd_ready_i(qr), .rd_data_o(qj)
  );

  sh64_back u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_ready_o(qr), .job_i(qj),
    .out_valid, .out_ready, .hash_value_o
  );
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stream_hash64: directed and random messages are
// streamed in under random idling; each hash transfer is checked against a
// local model of the hash kept in this bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] K0 = sh64_pkg::K0;
  localparam logic [63:0] K1 = sh64_pkg::K1;
  localparam logic [63:0] K2 = sh64_pkg::K2;
  localparam logic [63:0] K3 = sh64_pkg::K3;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] seed_i;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] data_word_i;
  logic [3:0]  byte_count_i;
  logic        last_i;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] hash_value_o;

  stream_hash64 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .seed_i       (seed_i),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_word_i  (data_word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hash_value_o (hash_value_o)
  );

  // Hash model state.
  logic [63:0] mdl_seed;
  logic [63:0] mdl_hash;
  logic [63:0] mdl_buf [3];
  int unsigned mdl_nbuf;
  bit          mdl_open;

  logic [63:0] expected_hashes [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          timed_out;

  // Directed table: a zero golden means "use the model".
  typedef struct {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
    logic [63:0] golden;
  } dir_row_t;

  function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned k);
    return (v >> k) | (v << (64 - k));
  endfunction

  function automatic void stripe_mix(input logic [63:0] w3);
    logic [63:0] h, a, b, c, d;
    h = mdl_hash;
    a = ror(mdl_buf[0] * K0, 29) + h;
    b = ror(mdl_buf[1] * K1, 29) + h;
    c = ror(mdl_buf[2] * K2, 29) + h;
    d = ror(w3 * K3, 29) + h;
    a ^= ror(a * K0 + d, 37) * K1;
    b ^= ror(b * K1 + c, 37) * K0;
    c ^= ror(c * K0 + b, 37) * K1;
    d ^= ror(d * K1 + a, 37) * K0;
    mdl_hash = h + (a ^ b);
  endfunction

  function automatic logic [63:0] tail_load(input logic [7:0] tb [32], input int unsigned p,
                                            input int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) v |= 64'(tb[p + i]) << (8 * i);
    return v;
  endfunction

  function automatic logic [63:0] tail_finish(input logic [7:0] tb [32],
                                              input int unsigned len);
    logic [63:0] h, a, b;
    int unsigned p;
    h = mdl_hash;
    p = 0;
    if (p + 16 <= len) begin
      a = ror(h + tail_load(tb, p, 8) * K2, 29) * K3;
      b = ror(h + tail_load(tb, p + 8, 8) * K2, 29) * K3;
      a ^= ror(a * K0, 21) + b;
      b ^= ror(b * K3, 21) + a;
      h += b;
      p += 16;
    end
    if (p + 8 <= len) begin
      h += tail_load(tb, p, 8) * K3;
      h ^= ror(h, 55) * K1;
      p += 8;
    end
    if (p + 4 <= len) begin
      h += tail_load(tb, p, 4) * K3;
      h ^= ror(h, 26) * K1;
      p += 4;
    end
    if (p + 2 <= len) begin
      h += tail_load(tb, p, 2) * K3;
      h ^= ror(h, 48) * K1;
      p += 2;
    end
    if (p < len) begin
      h += 64'(tb[p]) * K3;
      h ^= ror(h, 37) * K1;
    end
    h ^= ror(h, 28);
    h *= K0;
    h ^= ror(h, 29);
    return h;
  endfunction

  // Advance the hash model by one word; return 1 with the hash on a last word.
  function automatic bit hash_word(input logic [63:0] word, input logic [3:0] cnt,
                                   input logic last, output logic [63:0] hv);
    logic [7:0]  tb [32];
    int unsigned n, c, len;
    hv = '0;
    if (!mdl_open) begin
      mdl_hash = (mdl_seed + K2) * K0;
      mdl_nbuf = 0;
      mdl_open = 1;
    end
    if (!last) begin
      if (mdl_nbuf >= 3) begin
        stripe_mix(word);
        mdl_nbuf = 0;
      end else begin
        mdl_buf[mdl_nbuf] = word;
        mdl_nbuf++;
      end
      return 0;
    end
    c = (cnt > 8) ? 8 : cnt;
    n = mdl_nbuf;
    if (n == 3 && c == 8) begin
      stripe_mix(word);
      n = 0;
      c = 0;
    end
    for (int i = 0; i < 32; i++) tb[i] = '0;
    len = 0;
    for (int unsigned i = 0; i < n; i++)
      for (int unsigned j = 0; j < 8; j++) tb[len++] = mdl_buf[i][8*j +: 8];
    for (int unsigned i = 0; i < c; i++) tb[len++] = word[8*i +: 8];
    hv = tail_finish(tb, len);
    mdl_nbuf = 0;
    mdl_open = 0;
    return 1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1;
      $display("timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, compare each hash transfer with the oldest.
  initial begin
    int unsigned stall;
    logic [63:0] exp_hash;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      if (expected_hashes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected hash transfer %h", hash_value_o);
      end else begin
        exp_hash = expected_hashes.pop_front();
        if (hash_value_o !== exp_hash) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("hash mismatch: expected %h actual %h", exp_hash, hash_value_o);
        end
      end
    end
  end

  task automatic write_seed(input logic [63:0] s);
    // Wait out any in-flight work before touching the register.
    wait (expected_hashes.size() == 0);
    repeat (30) @(posedge clk_i);
    cfg_valid <= 1'b1;
    seed_i    <= s;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    mdl_seed = s;
  endtask

  // Send one word after a random gap unless burst is set; hold valid until the transfer.
  task automatic send_word(input logic [63:0] word, input logic [3:0] cnt,
                           input logic last, input logic [63:0] golden, input bit burst);
    logic [63:0] hv;
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    data_word_i  <= word;
    byte_count_i <= cnt;
    last_i       <= last;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    if (hash_word(word, cnt, last, hv)) begin
      if (golden != 0 && golden !== hv) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("model disagrees with table: table %h model %h", golden, hv);
      end
      expected_hashes.insert(expected_hashes.size(), hv);
    end
  endtask

  task automatic send_message(input int unsigned nwords, input bit burst);
    logic [3:0] cnt;
    for (int unsigned i = 0; i < nwords; i++) begin
      cnt = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 1)) cnt = 4'($urandom_range(0, 8));
      send_word({$urandom, $urandom}, cnt, i == nwords - 1, 64'd0, burst);
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    dir_row_t    dir_rows [$];
    int unsigned sent;
    int unsigned nw;
    bit          burst;
    logic [63:0] seeds [4];

    timed_out      = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    mdl_seed       = '0;
    mdl_hash       = '0;
    mdl_nbuf       = 0;
    mdl_open       = 0;
    for (int i = 0; i < 3; i++) mdl_buf[i] = '0;
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    seed_i       = '0;
    in_valid     = 1'b0;
    data_word_i  = '0;
    byte_count_i = '0;
    last_i       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, every tail length class, oversized counts,
    // full final stripe, all-ones data, non-last word with odd counts.
    dir_rows = '{
      '{64'h0, 4'd0, 1'b1, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 4'd1, 1'b1, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 4'd2, 1'b1, 64'h0},
      '{64'h0123_4567_89AB_CDEF, 4'd7, 1'b1, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 64'h0},
      '{64'h1111_1111_1111_1111, 4'd0, 1'b0, 64'h0},
      '{64'h2222_2222_2222_2222, 4'd3, 1'b1, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 64'h0},
      '{64'h0, 4'd5, 1'b0, 64'h0},
      '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b1, 64'h0},
      '{64'h1, 4'd9, 1'b0, 64'h0},
      '{64'h2, 4'd8, 1'b0, 64'h0},
      '{64'h3, 4'd8, 1'b0, 64'h0},
      '{64'h4, 4'd8, 1'b1, 64'h0},
      '{64'h5, 4'd8, 1'b0, 64'h0},
      '{64'h6, 4'd8, 1'b0, 64'h0},
      '{64'h7, 4'd8, 1'b0, 64'h0},
      '{64'h8, 4'd8, 1'b0, 64'h0},
      '{64'h9, 4'd0, 1'b1, 64'h0},
      '{64'h5555_5555_5555_5555, 4'd0, 1'b0, 64'h0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1, 64'h0}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].cnt, dir_rows[i].last,
                dir_rows[i].golden, 1'b0);
    in_valid <= 1'b0;

    // Random phases over several seeds, extremes included.
    seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, {$urandom, $urandom},
              64'h8000_0000_0000_0001};
    sent = 0;
    for (int p = 0; p < 4; p++) begin
      write_seed(seeds[p]);
      while (sent < 235 * (p + 1)) begin
        nw    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 9);
        burst = ($urandom_range(0, 5) == 0);
        send_message(nw, burst);
        sent += nw;
        // Hold off until the block has drained, now and then.
        if ($urandom_range(0, 15) == 0) wait (expected_hashes.size() == 0);
      end
      // Leave a message open across a seed write: the new seed applies later.
      if (p == 1) begin
        wait (expected_hashes.size() == 0);
        send_word({$urandom, $urandom}, 4'd8, 1'b0, 64'd0, 1'b0);
        in_valid <= 1'b0;
        repeat (30) @(posedge clk_i);
        cfg_valid <= 1'b1;
        seed_i    <= {$urandom, $urandom};
        do @(posedge clk_i); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        send_word({$urandom, $urandom}, 4'd6, 1'b1, 64'd0, 1'b0);
        in_valid <= 1'b0;
        mdl_seed = seed_i;
      end
    end

    wait (expected_hashes.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_hashes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
